[sv/sms_pkg.sv]
// Shared constants and types for the stable merge sorter.
// Depends on nothing; every other file of the block imports it.
package sms_pkg;

   localparam int CAPACITY = 64;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = ADDR_W + 1;
   localparam int DATA_W   = 32;

   typedef logic [DATA_W-1:0] data_type;
   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [CNT_W-1:0]  cnt_type;

   // memory requests issued by the merge sequencer
   typedef struct packed {
      addr_type rd_a;
      addr_type rd_b;
      logic     wr_en;
      addr_type wr_addr;
      data_type wr_data;
      logic     src_sel;
   } mem_req_type;

endpackage

[sv/sms_if.sv]
// Valid/ready channel interfaces for the sorter's input and result beats.
// Depends on sms_pkg for the data width.
interface sms_req_if;
   import sms_pkg::*;
   logic     valid;
   logic     ready;
   data_type value;
   logic     last;
   modport source (output valid, value, last, input ready);
   modport sink (input valid, value, last, output ready);
endinterface

interface sms_rsp_if;
   import sms_pkg::*;
   logic     valid;
   logic     ready;
   data_type sorted_value;
   logic     final_res;
   logic     overflowed;
   modport source (output valid, sorted_value, final_res, overflowed, input ready);
   modport sink (input valid, sorted_value, final_res, overflowed, output ready);
endinterface

[sv/sms_ram.sv]
// Element memory: one write port, two registered read ports.
// Depends on sms_pkg for depth and width.
module sms_ram
   import sms_pkg::*;
(
   input  logic     clock,
   input  logic     we,
   input  addr_type waddr,
   input  data_type wdata,
   input  addr_type ra,
   input  addr_type rb,
   output data_type qa,
   output data_type qb
);

   data_type mem [CAPACITY];
   data_type qa_ff;
   data_type qb_ff;

   // write one entry, read two, data registered
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      qa_ff <= mem[ra];
      qb_ff <= mem[rb];
   end

   assign qa = qa_ff;
   assign qb = qb_ff;

endmodule

[sv/sms_merge.sv]
// Merge sequencer: bottom-up merge passes of doubling run width over two
// ping-pong memories, one element through the shared compare unit a cycle.
// Depends on sms_pkg.
module sms_merge
   import sms_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  cnt_type     n,
   input  data_type    head_a,
   input  data_type    head_b,
   output mem_req_type mreq,
   output logic        done
);

   typedef enum logic [2:0] {
      M_IDLE = 3'b001,
      M_RUN  = 3'b010,
      M_GAP  = 3'b100
   } m_state_type;

   m_state_type state_ff, state_in;
   cnt_type     n_ff, n_in;
   cnt_type     w_ff, w_in;
   cnt_type     a_ff, a_in;
   cnt_type     mid_ff, mid_in;
   cnt_type     b_ff, b_in;
   cnt_type     hi_ff, hi_in;
   cnt_type     k_ff, k_in;
   logic        src_ff, src_in;

   logic        a_ok;
   logic        b_ok;
   logic        take_a;
   cnt_type     k_nx;
   cnt_type     w2;

   // clamp a run bound to the batch size
   function automatic cnt_type clamp(input logic [CNT_W:0] x, input cnt_type lim);
      clamp = (x > {1'b0, lim}) ? lim : x[CNT_W-1:0];
   endfunction

   always_comb begin
      state_in = state_ff;
      n_in     = n_ff;
      w_in     = w_ff;
      a_in     = a_ff;
      mid_in   = mid_ff;
      b_in     = b_ff;
      hi_in    = hi_ff;
      k_in     = k_ff;
      src_in   = src_ff;
      a_ok     = a_ff < mid_ff;
      b_ok     = b_ff < hi_ff;
      // left run wins ties to keep the sort stable
      take_a   = a_ok && (!b_ok || ($signed(head_a) <= $signed(head_b)));
      k_nx     = k_ff + 1'b1;
      w2       = {w_ff[CNT_W-2:0], 1'b0};

      unique case (state_ff)
         M_IDLE: begin
            if (start) begin
               n_in     = n;
               w_in     = cnt_type'(1);
               a_in     = '0;
               mid_in   = clamp((CNT_W+1)'(1), n);
               b_in     = clamp((CNT_W+1)'(1), n);
               hi_in    = clamp((CNT_W+1)'(2), n);
               k_in     = '0;
               src_in   = 1'b0;
               state_in = M_GAP;
            end
         end
         // an idle state between passes lets the head reads see the last write
         M_GAP: begin
            if (w_ff >= n_ff) begin
               state_in = M_IDLE;
            end else begin
               state_in = M_RUN;
            end
         end
         M_RUN: begin
            if (take_a) begin
               a_in = a_ff + 1'b1;
            end else begin
               b_in = b_ff + 1'b1;
            end
            k_in = k_nx;
            if (k_nx == hi_ff) begin
               if (hi_ff == n_ff) begin
                  // pass done: double the width, swap source and destination
                  w_in     = w2;
                  a_in     = '0;
                  mid_in   = clamp({1'b0, w2}, n_ff);
                  b_in     = clamp({1'b0, w2}, n_ff);
                  hi_in    = clamp({w2, 1'b0}, n_ff);
                  k_in     = '0;
                  src_in   = ~src_ff;
                  state_in = M_GAP;
               end else begin
                  // advance to the next pair of runs
                  a_in   = hi_ff;
                  mid_in = clamp({1'b0, hi_ff} + {1'b0, w_ff}, n_ff);
                  b_in   = clamp({1'b0, hi_ff} + {1'b0, w_ff}, n_ff);
                  hi_in  = clamp({1'b0, hi_ff} + {w_ff, 1'b0}, n_ff);
                  k_in   = hi_ff;
               end
            end
         end
         default: begin
            state_in = M_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= M_IDLE;
         src_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         src_ff   <= src_in;
      end
      n_ff   <= n_in;
      w_ff   <= w_in;
      a_ff   <= a_in;
      mid_ff <= mid_in;
      b_ff   <= b_in;
      hi_ff  <= hi_in;
      k_ff   <= k_in;
   end

   assign mreq.rd_a    = a_in[ADDR_W-1:0];
   assign mreq.rd_b    = b_in[ADDR_W-1:0];
   assign mreq.wr_en   = (state_ff == M_RUN);
   assign mreq.wr_addr = k_ff[ADDR_W-1:0];
   assign mreq.wr_data = take_a ? head_a : head_b;
   assign mreq.src_sel = src_ff;
   assign done         = (state_ff == M_GAP) && (w_ff >= n_ff);

endmodule

[sv/stable_merge_sorter.sv]
// Stable merge sorter. Each input beat is stored in ram 0; the beat
// flagged last closes the batch of n values (at most 64, extras dropped and
// flagged as overflowed) and the block stops taking input. The sort then runs
// ceil(log2 n) bottom-up merge passes through one shared signed
// compare-and-select unit fed by the two read ports of the source memory;
// result beats then leave one per cycle while the output is not stalled,
// after a prefetch state. Input is taken again as soon as the last result
// sits in the output register.
module stable_merge_sorter
   import sms_pkg::*;
(
   input logic         clock,
   input logic         reset,
   sms_req_if.sink     req_bus,
   sms_rsp_if.source   rsp_bus
);

   typedef enum logic [3:0] {
      S_LOAD = 4'b0001,
      S_SORT = 4'b0010,
      S_PRE  = 4'b0100,
      S_EMIT = 4'b1000
   } state_type;

   state_type   state_ff, state_in;
   cnt_type     count_ff, count_in;
   logic        ovf_ff, ovf_in;
   cnt_type     e_idx_ff, e_idx_in;
   logic        out_valid_ff, out_valid_in;
   data_type    out_value_ff, out_value_in;
   logic        out_final_ff, out_final_in;
   logic        out_ovf_ff, out_ovf_in;

   logic        req_beat;
   logic        store_en;
   logic        merge_start;
   logic        merge_done;
   logic        emit_mode;
   logic        out_load;
   mem_req_type mreq;

   logic        r0_we, r1_we;
   addr_type    r0_waddr, r1_waddr;
   data_type    r0_wdata, r1_wdata;
   addr_type    rd_a;
   data_type    r0_qa, r0_qb, r1_qa, r1_qb;
   data_type    head_a, head_b, emit_data;

   assign req_beat    = req_bus.valid && req_bus.ready;
   assign store_en    = req_beat && (count_ff < cnt_type'(CAPACITY));
   assign merge_start = req_beat && req_bus.last;
   assign emit_mode   = (state_ff == S_PRE) || (state_ff == S_EMIT);
   assign out_load    = (state_ff == S_EMIT) && (!out_valid_ff || rsp_bus.ready);

   // batch control, emit counter and output register
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      e_idx_in     = e_idx_ff;
      out_valid_in = out_valid_ff && !rsp_bus.ready;
      out_value_in = out_value_ff;
      out_final_in = out_final_ff;
      out_ovf_in   = out_ovf_ff;

      unique case (state_ff)
         S_LOAD: begin
            if (req_beat) begin
               if (store_en) begin
                  count_in = count_ff + 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_bus.last) begin
                  state_in = S_SORT;
               end
            end
         end
         S_SORT: begin
            if (merge_done) begin
               state_in = S_PRE;
            end
         end
         S_PRE: begin
            e_idx_in = '0;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (out_load) begin
               out_valid_in = 1'b1;
               out_value_in = emit_data;
               out_final_in = (e_idx_ff == count_ff - 1'b1);
               out_ovf_in   = ovf_ff;
               e_idx_in     = e_idx_ff + 1'b1;
               if (e_idx_ff == count_ff - 1'b1) begin
                  count_in = '0;
                  ovf_in   = 1'b0;
                  state_in = S_LOAD;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         out_valid_ff <= out_valid_in;
      end
      e_idx_ff     <= e_idx_in;
      out_value_ff <= out_value_in;
      out_final_ff <= out_final_in;
      out_ovf_ff   <= out_ovf_in;
   end

   // steer memory ports: loading fills ram 0, merging writes the destination
   always_comb begin
      r0_we    = store_en || (mreq.wr_en && mreq.src_sel);
      r0_waddr = store_en ? count_ff[ADDR_W-1:0] : mreq.wr_addr;
      r0_wdata = store_en ? req_bus.value : mreq.wr_data;
      r1_we    = mreq.wr_en && !mreq.src_sel;
      r1_waddr = mreq.wr_addr;
      r1_wdata = mreq.wr_data;
      rd_a     = emit_mode ? e_idx_in[ADDR_W-1:0] : mreq.rd_a;
      head_a   = mreq.src_sel ? r1_qa : r0_qa;
      head_b   = mreq.src_sel ? r1_qb : r0_qb;
      emit_data = head_a;
   end

   sms_ram u_ram0 (
      .clock (clock),
      .we    (r0_we),
      .waddr (r0_waddr),
      .wdata (r0_wdata),
      .ra    (rd_a),
      .rb    (mreq.rd_b),
      .qa    (r0_qa),
      .qb    (r0_qb)
   );

   sms_ram u_ram1 (
      .clock (clock),
      .we    (r1_we),
      .waddr (r1_waddr),
      .wdata (r1_wdata),
      .ra    (rd_a),
      .rb    (mreq.rd_b),
      .qa    (r1_qa),
      .qb    (r1_qb)
   );

   sms_merge u_merge (
      .clock  (clock),
      .reset  (reset),
      .start  (merge_start),
      .n      (count_in),
      .head_a (head_a),
      .head_b (head_b),
      .mreq   (mreq),
      .done   (merge_done)
   );

   assign req_bus.ready        = (state_ff == S_LOAD);
   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.sorted_value = out_value_ff;
   assign rsp_bus.final_res    = out_final_ff;
   assign rsp_bus.overflowed   = out_ovf_ff;

endmodule

[sv/sms_checker.sv]
// Port-level checks for the stable merge sorter, attached by bind.
// Depends on sms_pkg and on the top level's channel ports.
module sms_checker
   import sms_pkg::*;
(
   input logic     clock,
   input logic     reset,
   input logic     req_valid,
   input logic     req_ready,
   input logic     req_last,
   input logic     rsp_valid,
   input logic     rsp_ready,
   input data_type rsp_value,
   input logic     rsp_final,
   input logic     rsp_ovf
);

   // hold a stalled result beat
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value)
         && $stable(rsp_final) && $stable(rsp_ovf))
      else $error("stalled result beat changed");

   // drop input ready once a batch closes
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last |=> !req_ready)
      else $error("input taken after batch close");

   // advance results back to back inside a batch, same overflow flag
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_final |=> rsp_valid && (rsp_ovf == $past(rsp_ovf)))
      else $error("gap or overflow change inside a batch");

   // open the input only once the batch is drained down to its final beat
   assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid || rsp_final)
      else $error("input open while a batch is still draining");

endmodule

bind stable_merge_sorter sms_checker u_sms_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .req_last  (req_bus.last),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsp_value (rsp_bus.sorted_value),
   .rsp_final (rsp_bus.final_res),
   .rsp_ovf   (rsp_bus.overflowed)
);
